>>> sv/rational_arithmetic_unit_macros.svh
// assertion helpers for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define RAU_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rational unit check failed");

// next-cycle implication, checked out of reset
`define RAU_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rational unit sequencing check failed");

`endif

>>> sv/rau_pkg.sv
package rau_pkg;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RCHK,
    S_GCD,
    S_DIV,
    S_RFIN,
    S_RDONE,
    S_MINIT,
    S_MUL,
    S_EVAL,
    S_OUT
  } rau_state_t;

  // which fraction the reduce sequence is working on
  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_R
  } rau_phase_t;

  // operation codes
  typedef enum logic [3:0] {
    OP_NORM = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_ABS  = 4'd5,
    OP_NEG  = 4'd6,
    OP_EQ   = 4'd7,
    OP_NE   = 4'd8,
    OP_LT   = 4'd9,
    OP_LE   = 4'd10,
    OP_GT   = 4'd11,
    OP_GE   = 4'd12
  } rau_op_t;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_ZDEN = 2'd1;
  localparam logic [1:0] ERR_DIVZ = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load_wb;
    logic load_weval;
    logic rsetup;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic fin;
    logic store_a;
    logic store_b;
    logic mul_start;
    logic mul_step;
    logic res_direct;
    logic res_red;
    logic res_zden;
  } rau_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic wd_zero;
    logic wn_zero;
    logic gcd_eq;
    logic cnt_last;
    logic red_err;
    logic binary;
    logic eval_reduce;
  } rau_sts_t;

endpackage

>>> sv/rau_dp.sv
module rau_dp
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  rau_cmd_t           cmd,
  output rau_sts_t           sts,
  input  logic [3:0]         in_operation,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic               out_compare_true,
  output logic [1:0]         out_error_code
);

  localparam int CW = $clog2(WIDTH);
  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

  function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] x);
    mag = x[WIDTH-1] ? (~x + ONE) : x;
  endfunction

  // request registers
  logic [3:0]       op_r;
  logic [WIDTH-1:0] rb_n_r, rb_d_r;
  // fraction under reduction
  logic [WIDTH-1:0] w_n_r, w_d_r;
  logic             neg_r;
  logic [WIDTH-1:0] mn_r, md_r;
  // gcd
  logic [WIDTH-1:0] u_r, v_r, g_r;
  logic [CW-1:0]    k_r;
  // dividers
  logic [WIDTH-1:0] qn_r, qd_r;
  logic [WIDTH:0]   remn_r, remd_r;
  logic [CW-1:0]    cnt_r;
  // reduced fraction
  logic [WIDTH-1:0] red_n_r, red_d_r;
  logic             red_err_r;
  // operands
  logic [WIDTH-1:0] a_n_r, a_d_r, b_n_r, b_d_r;
  // multipliers
  logic [WIDTH-1:0] sa_n_r, sb_n_r, sa_d_r;
  logic [WIDTH-1:0] ma_d_r, mb_d_r, mb_n_r;
  logic [WIDTH-1:0] pad_r, pbc_r, pdd_r, pnn_r, pdb_r;
  // result
  logic [WIDTH-1:0] res_n_r, res_d_r;
  logic             cmp_r;
  logic [1:0]       err_r;

  // divider step values
  logic [WIDTH:0] shn, shd, subn, subd;
  assign shn  = {remn_r[WIDTH-1:0], qn_r[WIDTH-1]};
  assign shd  = {remd_r[WIDTH-1:0], qd_r[WIDTH-1]};
  assign subn = shn - {1'b0, g_r};
  assign subd = shd - {1'b0, g_r};

  // op decode
  logic bin_op, red_op;
  always_comb begin
    bin_op = 1'b0;
    red_op = 1'b0;
    unique case (op_r)
      OP_ADD, OP_SUB, OP_MUL: begin
        bin_op = 1'b1;
        red_op = 1'b1;
      end
      OP_DIV: begin
        bin_op = 1'b1;
        red_op = (b_n_r != '0);
      end
      OP_ABS, OP_NEG: red_op = 1'b1;
      OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: bin_op = 1'b1;
      default: ;
    endcase
  end

  // status
  always_comb begin
    sts.wd_zero     = (w_d_r == '0);
    sts.wn_zero     = (w_n_r == '0);
    sts.gcd_eq      = (u_r == v_r);
    sts.cnt_last    = (cnt_r == CW'(WIDTH - 1));
    sts.red_err     = red_err_r;
    sts.binary      = bin_op;
    sts.eval_reduce = red_op;
  end

  // comparison of cross products
  logic lt_ab, lt_ba, cmp_v;
  assign lt_ab = $signed(pad_r) < $signed(pbc_r);
  assign lt_ba = $signed(pbc_r) < $signed(pad_r);
  always_comb begin
    unique case (op_r)
      OP_EQ:   cmp_v = (pad_r == pbc_r);
      OP_NE:   cmp_v = (pad_r != pbc_r);
      OP_LT:   cmp_v = lt_ab;
      OP_LE:   cmp_v = !lt_ba;
      OP_GT:   cmp_v = lt_ba;
      OP_GE:   cmp_v = !lt_ab;
      default: cmp_v = 1'b0;
    endcase
  end

  // fraction to reduce after the products
  logic [WIDTH-1:0] ev_n, ev_d;
  always_comb begin
    ev_n = w_n_r;
    ev_d = w_d_r;
    unique case (op_r)
      OP_ADD: begin ev_n = pad_r + pbc_r; ev_d = pdd_r; end
      OP_SUB: begin ev_n = pad_r - pbc_r; ev_d = pdd_r; end
      OP_MUL: begin ev_n = pnn_r;         ev_d = pdd_r; end
      OP_DIV: begin ev_n = pad_r;         ev_d = pdb_r; end
      OP_ABS: begin ev_n = mag(a_n_r);    ev_d = a_d_r; end
      OP_NEG: begin ev_n = ~a_n_r + ONE;  ev_d = a_d_r; end
      default: ;
    endcase
  end

  // request capture and reduce input
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_operation;
      w_n_r  <= WIDTH'(in_a_num);
      w_d_r  <= WIDTH'(in_a_den);
      rb_n_r <= WIDTH'(in_b_num);
      rb_d_r <= WIDTH'(in_b_den);
    end else if (cmd.load_wb) begin
      w_n_r <= rb_n_r;
      w_d_r <= rb_d_r;
    end else if (cmd.load_weval) begin
      w_n_r <= ev_n;
      w_d_r <= ev_d;
    end
  end

  // binary gcd
  always_ff @(posedge clk) begin
    if (cmd.rsetup) begin
      neg_r <= w_n_r[WIDTH-1] ^ w_d_r[WIDTH-1];
      mn_r  <= mag(w_n_r);
      md_r  <= mag(w_d_r);
      u_r   <= mag(w_n_r);
      v_r   <= mag(w_d_r);
      k_r   <= '0;
    end else if (cmd.gcd_step) begin
      priority if (!u_r[0] && !v_r[0]) begin
        u_r <= u_r >> 1;
        v_r <= v_r >> 1;
        k_r <= k_r + CW'(1);
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (u_r > v_r) begin
        u_r <= (u_r - v_r) >> 1;
      end else begin
        v_r <= (v_r - u_r) >> 1;
      end
    end
  end

  // shared step counter
  always_ff @(posedge clk) begin
    if (cmd.div_init || cmd.mul_start) begin
      cnt_r <= '0;
    end else if (cmd.div_step || cmd.mul_step) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  // two restoring dividers by the gcd
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      g_r    <= u_r << k_r;
      qn_r   <= mn_r;
      qd_r   <= md_r;
      remn_r <= '0;
      remd_r <= '0;
    end else if (cmd.div_step) begin
      remn_r <= subn[WIDTH] ? shn : subn;
      remd_r <= subd[WIDTH] ? shd : subd;
      qn_r   <= {qn_r[WIDTH-2:0], ~subn[WIDTH]};
      qd_r   <= {qd_r[WIDTH-2:0], ~subd[WIDTH]};
    end
  end

  // reduced fraction
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      priority if (w_d_r == '0) begin
        red_n_r   <= '0;
        red_d_r   <= ONE;
        red_err_r <= 1'b1;
      end else if (w_n_r == '0) begin
        red_n_r   <= '0;
        red_d_r   <= ONE;
        red_err_r <= 1'b0;
      end else if (qd_r[WIDTH-1]) begin
        red_n_r   <= '0;
        red_d_r   <= ONE;
        red_err_r <= 1'b1;
      end else begin
        red_n_r   <= neg_r ? (~qn_r + ONE) : qn_r;
        red_d_r   <= qd_r;
        red_err_r <= 1'b0;
      end
    end
  end

  // normalized operands
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      b_n_r <= '0;
      b_d_r <= ONE;
    end else if (cmd.store_b) begin
      b_n_r <= red_n_r;
      b_d_r <= red_d_r;
    end
    if (cmd.store_a) begin
      a_n_r <= red_n_r;
      a_d_r <= red_d_r;
    end
  end

  // five shift-add multipliers, low bits only
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      sa_n_r <= a_n_r;
      sb_n_r <= b_n_r;
      sa_d_r <= a_d_r;
      ma_d_r <= a_d_r;
      mb_d_r <= b_d_r;
      mb_n_r <= b_n_r;
      pad_r  <= '0;
      pbc_r  <= '0;
      pdd_r  <= '0;
      pnn_r  <= '0;
      pdb_r  <= '0;
    end else if (cmd.mul_step) begin
      if (mb_d_r[0]) pad_r <= pad_r + sa_n_r;
      if (ma_d_r[0]) pbc_r <= pbc_r + sb_n_r;
      if (mb_d_r[0]) pdd_r <= pdd_r + sa_d_r;
      if (mb_n_r[0]) pnn_r <= pnn_r + sa_n_r;
      if (mb_n_r[0]) pdb_r <= pdb_r + sa_d_r;
      sa_n_r <= sa_n_r << 1;
      sb_n_r <= sb_n_r << 1;
      sa_d_r <= sa_d_r << 1;
      ma_d_r <= ma_d_r >> 1;
      mb_d_r <= mb_d_r >> 1;
      mb_n_r <= mb_n_r >> 1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_zden) begin
      res_n_r <= '0;
      res_d_r <= ONE;
      cmp_r   <= 1'b0;
      err_r   <= ERR_ZDEN;
    end else if (cmd.res_red) begin
      res_n_r <= red_n_r;
      res_d_r <= red_d_r;
      cmp_r   <= 1'b0;
      err_r   <= red_err_r ? ERR_ZDEN : ERR_NONE;
    end else if (cmd.res_direct) begin
      res_n_r <= (op_r == OP_NORM) ? a_n_r : '0;
      res_d_r <= (op_r == OP_NORM) ? a_d_r : ONE;
      cmp_r   <= cmp_v;
      err_r   <= (op_r == OP_DIV) ? ERR_DIVZ : ERR_NONE;
    end
  end

  assign out_res_num      = 32'($signed(res_n_r));
  assign out_res_den      = 31'(res_d_r);
  assign out_compare_true = cmp_r;
  assign out_error_code   = err_r;

endmodule

>>> sv/rau_ctrl.sv
`include "rational_arithmetic_unit_macros.svh"

module rau_ctrl
  import rau_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  rau_sts_t sts,
  output rau_cmd_t cmd
);

  rau_state_t state_r, state_nxt;
  rau_phase_t phase_r, phase_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_A;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RCHK;
          phase_nxt = PH_A;
        end
      end
      S_RCHK:  state_nxt = (sts.wd_zero || sts.wn_zero) ? S_RDONE : S_GCD;
      S_GCD:   if (sts.gcd_eq) state_nxt = S_DIV;
      S_DIV:   if (sts.cnt_last) state_nxt = S_RFIN;
      S_RFIN:  state_nxt = S_RDONE;
      S_RDONE: begin
        unique case (phase_r)
          PH_A: begin
            if (sts.red_err) begin
              state_nxt = S_OUT;
            end else if (sts.binary) begin
              state_nxt = S_RCHK;
              phase_nxt = PH_B;
            end else begin
              state_nxt = S_MINIT;
            end
          end
          PH_B:    state_nxt = sts.red_err ? S_OUT : S_MINIT;
          default: state_nxt = S_OUT;
        endcase
      end
      S_MINIT: state_nxt = S_MUL;
      S_MUL:   if (sts.cnt_last) state_nxt = S_EVAL;
      S_EVAL: begin
        if (sts.eval_reduce) begin
          state_nxt = S_RCHK;
          phase_nxt = PH_R;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: cmd.capture = in_valid;
      S_RCHK: begin
        if (sts.wd_zero || sts.wn_zero) cmd.fin = 1'b1;
        else cmd.rsetup = 1'b1;
      end
      S_GCD: begin
        if (sts.gcd_eq) cmd.div_init = 1'b1;
        else cmd.gcd_step = 1'b1;
      end
      S_DIV:  cmd.div_step = 1'b1;
      S_RFIN: cmd.fin = 1'b1;
      S_RDONE: begin
        unique case (phase_r)
          PH_A: begin
            if (sts.red_err) begin
              cmd.res_zden = 1'b1;
            end else begin
              cmd.store_a = 1'b1;
              cmd.load_wb = sts.binary;
            end
          end
          PH_B: begin
            if (sts.red_err) cmd.res_zden = 1'b1;
            else cmd.store_b = 1'b1;
          end
          default: cmd.res_red = 1'b1;
        endcase
      end
      S_MINIT: cmd.mul_start = 1'b1;
      S_MUL:   cmd.mul_step = 1'b1;
      S_EVAL: begin
        if (sts.eval_reduce) cmd.load_weval = 1'b1;
        else cmd.res_direct = 1'b1;
      end
      default: ;
    endcase
  end

  // handshake
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // checks
  `RAU_ASSERT_NEXT(a_accept_starts, clk, rst_n, state_r == S_IDLE && in_valid, state_r == S_RCHK)
  `RAU_ASSERT_NEXT(a_fin_done, clk, rst_n, state_r == S_RFIN, state_r == S_RDONE)
  `RAU_ASSERT_NEXT(a_hold_out, clk, rst_n, state_r == S_OUT && out_stall, state_r == S_OUT)
  `RAU_ASSERT_NEXT(a_last_red, clk, rst_n, state_r == S_RDONE && phase_r == PH_R, state_r == S_OUT)
  `RAU_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, in_stall)

endmodule

>>> sv/rational_arithmetic_unit.sv
// Rational arithmetic unit: one request (operation and two signed fractions)
// at a time, one result per request. Each fraction is reduced by a binary gcd
// (one subtract-and-shift step per cycle) followed by a pair of restoring
// dividers run side by side. A request reduces its first operand, its second
// operand for binary operations, runs five shift-add multipliers in parallel,
// and, for ADD, SUB, MUL, DIV (unless by zero), ABS and NEG, reduces the
// result once more. An operand whose reduction reports an error ends the
// request early, before the multipliers.
// The input stalls while a request is in flight, until its result has been
// taken.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_operation,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic               out_compare_true,
  output logic [1:0]         out_error_code
);

  rau_cmd_t cmd;
  rau_sts_t sts;

  // sequencer
  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic
  rau_dp #(.WIDTH(WIDTH)) u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_a_num         (in_a_num),
    .in_a_den         (in_a_den),
    .in_b_num         (in_b_num),
    .in_b_den         (in_b_den),
    .out_res_num      (out_res_num),
    .out_res_den      (out_res_den),
    .out_compare_true (out_compare_true),
    .out_error_code   (out_error_code)
  );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import rau_pkg::*;
();

  localparam int WIDTH = 32;
  localparam int RANDOM_ITEMS = 1400;

  // expected result of one request
  typedef struct {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               compare_true;
    logic [1:0]         error_code;
  } rau_result_t;

  // one fraction reduced to lowest terms
  typedef struct {
    logic [WIDTH-1:0] num;
    logic [WIDTH-1:0] den;
    logic [1:0]       err;
  } fraction_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         in_operation;
  logic signed [31:0] in_a_num;
  logic signed [31:0] in_a_den;
  logic signed [31:0] in_b_num;
  logic signed [31:0] in_b_den;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_res_num;
  logic [30:0]        out_res_den;
  logic               out_compare_true;
  logic [1:0]         out_error_code;

  rau_result_t expected_results[$];
  int          error_count;
  int          result_count;
  int          request_count;
  bit          stall_idle_off;
  bit          send_idle_off;

  rational_arithmetic_unit #(
    .WIDTH(WIDTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_a_num         (in_a_num),
    .in_a_den         (in_a_den),
    .in_b_num         (in_b_num),
    .in_b_den         (in_b_den),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_res_num      (out_res_num),
    .out_res_den      (out_res_den),
    .out_compare_true (out_compare_true),
    .out_error_code   (out_error_code)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

  // magnitude of a two's complement value
  function automatic logic [WIDTH-1:0] magnitude(logic [WIDTH-1:0] x);
    return x[WIDTH-1] ? -x : x;
  endfunction

  function automatic logic [WIDTH-1:0] euclid_gcd(logic [WIDTH-1:0] x, logic [WIDTH-1:0] y);
    logic [WIDTH-1:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // sign to numerator, reduce by gcd
  function automatic fraction_t reduce(logic [WIDTH-1:0] num, logic [WIDTH-1:0] den);
    fraction_t        f;
    logic             neg;
    logic [WIDTH-1:0] mn;
    logic [WIDTH-1:0] md;
    logic [WIDTH-1:0] g;
    f.num = '0;
    f.den = 1;
    f.err = ERR_NONE;
    if (den == 0) begin
      f.err = ERR_ZDEN;
      return f;
    end
    if (num == 0) return f;
    neg = num[WIDTH-1] ^ den[WIDTH-1];
    mn = magnitude(num);
    md = magnitude(den);
    g = euclid_gcd(mn, md);
    mn = mn / g;
    md = md / g;
    if (md[WIDTH-1]) begin
      f.err = ERR_ZDEN;
      return f;
    end
    f.num = neg ? -mn : mn;
    f.den = md;
    return f;
  endfunction

  function automatic rau_result_t compute_rational(logic [3:0] op, logic [31:0] an,
                                                   logic [31:0] ad_in, logic [31:0] bn,
                                                   logic [31:0] bd_in);
    rau_result_t      r;
    fraction_t        a;
    fraction_t        b;
    fraction_t        f;
    logic             binary;
    logic             cmp;
    logic [WIDTH-1:0] ad;
    logic [WIDTH-1:0] bc;
    a = reduce(WIDTH'(signed'(an)), WIDTH'(signed'(ad_in)));
    binary = (op >= OP_ADD && op <= OP_DIV) || (op >= OP_EQ && op <= OP_GE);
    b.num = '0;
    b.den = 1;
    b.err = ERR_NONE;
    if (binary) b = reduce(WIDTH'(signed'(bn)), WIDTH'(signed'(bd_in)));
    f.num = '0;
    f.den = 1;
    f.err = ERR_NONE;
    cmp = 1'b0;
    if (a.err != ERR_NONE || b.err != ERR_NONE) begin
      f.err = ERR_ZDEN;
    end else begin
      ad = a.num * b.den;
      bc = b.num * a.den;
      case (op)
        OP_NORM: f = a;
        OP_ADD:  f = reduce(ad + bc, a.den * b.den);
        OP_SUB:  f = reduce(ad - bc, a.den * b.den);
        OP_MUL:  f = reduce(a.num * b.num, a.den * b.den);
        OP_DIV: begin
          if (b.num == 0) f.err = ERR_DIVZ;
          else f = reduce(ad, a.den * b.num);
        end
        OP_ABS:  f = reduce(magnitude(a.num), a.den);
        OP_NEG:  f = reduce(-a.num, a.den);
        OP_EQ:   cmp = (ad == bc);
        OP_NE:   cmp = (ad != bc);
        OP_LT:   cmp = $signed(ad) < $signed(bc);
        OP_LE:   cmp = $signed(ad) <= $signed(bc);
        OP_GT:   cmp = $signed(ad) > $signed(bc);
        OP_GE:   cmp = $signed(ad) >= $signed(bc);
        default: ;
      endcase
    end
    if (f.err != ERR_NONE) begin
      f.num = '0;
      f.den = 1;
      cmp = 1'b0;
    end
    r.res_num = 32'(signed'(f.num));
    r.res_den = f.den[30:0];
    r.compare_true = cmp;
    r.error_code = f.err;
    return r;
  endfunction

  // send one request, predicting its result at acceptance
  task automatic send_request(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
                              logic [31:0] bn, logic [31:0] bd);
    while (!send_idle_off && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(compute_rational(op, an, ad, bn, bd));
    request_count++;
    @(negedge clk);
  endtask

  // random operand: mixes small, edge and full-range values
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'(signed'($urandom_range(4)) - 2);
      3, 4:    return $urandom();
      5:       return 32'(1) << $urandom_range(31);
      default: return 32'(signed'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    rau_op_t op;
    // each operation on plain operands
    op = op.first();
    forever begin
      send_request(op, -6, 4, 3, -9);
      if (op == op.last()) break;
      op = op.next();
    end
    // zero denominators, division by zero, extremes, unused codes
    send_request(OP_ADD, 1, 0, 1, 2);
    send_request(OP_EQ, 1, 2, 1, 0);
    send_request(OP_DIV, 5, 3, 0, 7);
    send_request(OP_DIV, 5, 0, 0, 7);
    send_request(OP_NORM, 32'h8000_0000, 32'hffff_ffff, 0, 1);
    send_request(OP_ABS, 32'h8000_0000, 1, 0, 1);
    send_request(OP_NORM, 1, 32'h8000_0000, 0, 1);
    send_request(OP_NORM, 0, -5, 0, 1);
    send_request(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 3);
    send_request(OP_MUL, 1, 65536, 1, 65536);
    send_request(13, 1, 2, 3, 4);
    send_request(15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_random(int count, bit no_idle);
    logic [3:0] op;
    send_idle_off = no_idle;
    stall_idle_off = no_idle;
    repeat (count) begin
      op = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(OP_GE));
      send_request(op, pick_value(), pick_value(), pick_value(), pick_value());
    end
    send_idle_off = 1'b0;
    stall_idle_off = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    rau_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $error("unexpected result");
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_res_num !== e.res_num) begin
          $error("res_num expected %0d actual %0d", e.res_num, out_res_num);
          error_count++;
        end
        if (out_res_den !== e.res_den) begin
          $error("res_den expected %0d actual %0d", e.res_den, out_res_den);
          error_count++;
        end
        if (out_compare_true !== e.compare_true) begin
          $error("compare_true expected %0b actual %0b", e.compare_true, out_compare_true);
          error_count++;
        end
        if (out_error_code !== e.error_code) begin
          $error("error_code expected %0d actual %0d", e.error_code, out_error_code);
          error_count++;
        end
      end
    end
  end

  // random result stall
  always @(negedge clk) begin
    out_stall <= !stall_idle_off && ($urandom_range(99) < 25);
  end

  initial begin
    int tail;
    error_count = 0;
    result_count = 0;
    request_count = 0;
    stall_idle_off = 1'b0;
    send_idle_off = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = '0;
    in_a_num = '0;
    in_a_den = '0;
    in_b_num = '0;
    in_b_den = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    // sender holds off until everything is back
    in_valid <= 1'b0;
    wait_drained();
    test_random(RANDOM_ITEMS - 300, 1'b0);
    test_random(200, 1'b1);
    test_random(100, 1'b0);
    in_valid <= 1'b0;

    tail = 0;
    while (expected_results.size() != 0 && tail < 20000) begin
      @(negedge clk);
      tail++;
    end
    repeat (400) @(negedge clk);
    $display("covered %0d requests, %0d results, all operations and error cases",
             request_count, result_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/rau_pkg.sv
sv/rau_dp.sv
sv/rau_ctrl.sv
sv/rational_arithmetic_unit.sv
test/tb_top.sv
